// File: rtl/integer_alu_with_nil_macros.svh
// ----------------------------------------------------------------------------
// integer alu with nil - assertion macros
// concurrent checks clocked on i_clk, held off while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef INTEGER_ALU_WITH_NIL_MACROS_SVH
`define INTEGER_ALU_WITH_NIL_MACROS_SVH
`ifndef SYNTHESIS
// property must hold in the same cycle as its trigger
`define IALU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ialu check failed");
// property must hold in the cycle after its trigger
`define IALU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ialu check failed");
`else
`define IALU_ASSERT_NOW(label, ante, cons)
`define IALU_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/ialu_pkg.sv
// ----------------------------------------------------------------------------
// ialu_pkg
// shared widths, codes and pipeline record types of the integer alu
// ----------------------------------------------------------------------------
`default_nettype none
package ialu_pkg;

    // datapath width, the low bits of each operand taken as two's complement
    localparam int DATA_WIDTH = 64;
    localparam int OUT_WIDTH  = 64;
    localparam int LO_WIDTH   = DATA_WIDTH / 2;
    localparam int HI_WIDTH   = DATA_WIDTH - LO_WIDTH;
    localparam int SH_WIDTH   = $clog2(DATA_WIDTH);

    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_MOD = 4'd4,
        OP_AND = 4'd5,
        OP_XOR = 4'd6,
        OP_OR  = 4'd7,
        OP_SHL = 4'd8,
        OP_SHR = 4'd9,
        OP_NEG = 4'd10,
        OP_NOT = 4'd11
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NIL      = 3'd1,
        ST_DIVZERO  = 3'd2,
        ST_SHIFT    = 3'd3,
        ST_OVERFLOW = 3'd4
    } t_status;

    // which datapath supplies the final value
    typedef enum logic [1:0] {
        SEL_SIMPLE,
        SEL_MUL,
        SEL_DIV,
        SEL_MOD
    } t_sel;

    // per-beat record carried alongside the divider chain
    typedef struct packed {
        t_sel                      sel;
        logic                      nil;
        t_status                   status;
        logic [DATA_WIDTH-1:0]     simple;
        logic [2*LO_WIDTH-1:0]     p_ll;
        logic [HI_WIDTH-1:0]       p_lh;
        logic [HI_WIDTH-1:0]       p_hl;
        logic                      q_neg;
        logic                      r_neg;
        logic [DATA_WIDTH-1:0]     divisor;
    } t_item;

    // divider state: partial remainder and dividend shifting into quotient
    typedef struct packed {
        logic [DATA_WIDTH-1:0] rem;
        logic [DATA_WIDTH-1:0] num;
    } t_div;

endpackage
`default_nettype wire

// File: rtl/ialu_front.sv
// ----------------------------------------------------------------------------
// ialu_front
// decode, fault checks, simple ops and multiplier partial products
// ----------------------------------------------------------------------------
`default_nettype none
module ialu_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_adv,
    input  wire logic                            i_valid,
    input  wire logic [3:0]                      i_opcode,
    input  wire logic [ialu_pkg::OUT_WIDTH-1:0]  i_operand_a,
    input  wire logic [ialu_pkg::OUT_WIDTH-1:0]  i_operand_b,
    input  wire logic                            i_a_is_nil,
    input  wire logic                            i_b_is_nil,
    output logic                                 o_valid,
    output ialu_pkg::t_item                      o_item,
    output ialu_pkg::t_div                       o_div
);
    localparam int W  = ialu_pkg::DATA_WIDTH;
    localparam int LO = ialu_pkg::LO_WIDTH;
    localparam int HI = ialu_pkg::HI_WIDTH;
    localparam logic [W-1:0] WVAL = W'(W);
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    logic            r_valid;
    ialu_pkg::t_item r_item;
    ialu_pkg::t_div  r_div;
    ialu_pkg::t_item n_item;
    ialu_pkg::t_div  n_div;

    logic [W-1:0]    a;
    logic [W-1:0]    b;
    logic [W-1:0]    mag_a;
    logic [W-1:0]    mag_b;
    logic            unary;
    logic            b_zero;
    logic            sh_bad;
    ialu_pkg::t_op   op;

    // operand views
    always_comb begin
        a      = i_operand_a[W-1:0];
        b      = i_operand_b[W-1:0];
        op     = ialu_pkg::t_op'(i_opcode);
        mag_a  = a[W-1] ? (~a + 1'b1) : a;
        mag_b  = b[W-1] ? (~b + 1'b1) : b;
        unary  = (op == ialu_pkg::OP_NEG) || (op == ialu_pkg::OP_NOT);
        b_zero = (b == '0);
        sh_bad = b[W-1] || (b >= WVAL);
    end

    // decode and simple-op results
    always_comb begin
        n_item         = '0;
        n_item.sel     = ialu_pkg::SEL_SIMPLE;
        n_item.status  = ialu_pkg::ST_OK;
        n_item.p_ll    = (2*LO)'(a[LO-1:0]) * (2*LO)'(b[LO-1:0]);
        n_item.p_lh    = HI'(a[LO-1:0]) * b[W-1:LO];
        n_item.p_hl    = a[W-1:LO] * HI'(b[LO-1:0]);
        n_item.q_neg   = a[W-1] ^ b[W-1];
        n_item.r_neg   = a[W-1];
        n_item.divisor = mag_b;
        n_div.rem      = '0;
        n_div.num      = mag_a;
        unique case (op)
            ialu_pkg::OP_ADD: n_item.simple = a + b;
            ialu_pkg::OP_SUB: n_item.simple = a - b;
            ialu_pkg::OP_MUL: n_item.sel = ialu_pkg::SEL_MUL;
            ialu_pkg::OP_DIV: begin
                n_item.sel = ialu_pkg::SEL_DIV;
                if (b_zero) begin
                    n_item.nil    = 1'b1;
                    n_item.status = ialu_pkg::ST_DIVZERO;
                end else if (a == MINV && b == '1) begin
                    n_item.nil    = 1'b1;
                    n_item.status = ialu_pkg::ST_OVERFLOW;
                end
            end
            ialu_pkg::OP_MOD: begin
                n_item.sel = ialu_pkg::SEL_MOD;
                if (b_zero) begin
                    n_item.nil    = 1'b1;
                    n_item.status = ialu_pkg::ST_DIVZERO;
                end
            end
            ialu_pkg::OP_AND: n_item.simple = a & b;
            ialu_pkg::OP_XOR: n_item.simple = a ^ b;
            ialu_pkg::OP_OR:  n_item.simple = a | b;
            ialu_pkg::OP_SHL: begin
                n_item.simple = a << b[ialu_pkg::SH_WIDTH-1:0];
                if (sh_bad) begin
                    n_item.nil    = 1'b1;
                    n_item.status = ialu_pkg::ST_SHIFT;
                end
            end
            ialu_pkg::OP_SHR: begin
                n_item.simple = W'($signed(a) >>> b[ialu_pkg::SH_WIDTH-1:0]);
                if (sh_bad) begin
                    n_item.nil    = 1'b1;
                    n_item.status = ialu_pkg::ST_SHIFT;
                end
            end
            ialu_pkg::OP_NEG: n_item.simple = ~a + 1'b1;
            ialu_pkg::OP_NOT: n_item.simple = ~a;
            default:          n_item.simple = '0;
        endcase
        // nil operands win over every other fault; unused opcodes never nil
        if (i_opcode <= ialu_pkg::OP_NOT && (i_a_is_nil || (!unary && i_b_is_nil))) begin
            n_item.nil    = 1'b1;
            n_item.status = ialu_pkg::ST_NIL;
        end
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
        if (i_adv) begin
            r_item <= n_item;
            r_div  <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign o_div   = r_div;
endmodule
`default_nettype wire

// File: rtl/ialu_cell.sv
// ----------------------------------------------------------------------------
// ialu_cell
// one restoring divide step, moves its beat to the next cell each i_adv cycle
// ----------------------------------------------------------------------------
`default_nettype none
module ialu_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_adv,
    input  wire logic            i_valid,
    input  ialu_pkg::t_item      i_item,
    input  ialu_pkg::t_div       i_div,
    output logic                 o_valid,
    output ialu_pkg::t_item      o_item,
    output ialu_pkg::t_div       o_div
);
    localparam int W = ialu_pkg::DATA_WIDTH;

    logic            r_valid;
    ialu_pkg::t_item r_item;
    ialu_pkg::t_div  r_div;
    ialu_pkg::t_div  n_div;
    logic [W-1:0]    trial;
    logic            fits;

    // shift in next dividend bit, subtract divisor when it fits
    always_comb begin
        trial     = {i_div.rem[W-2:0], i_div.num[W-1]};
        fits      = (trial >= i_item.divisor);
        n_div.rem = fits ? (trial - i_item.divisor) : trial;
        n_div.num = {i_div.num[W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
        if (i_adv) begin
            r_item <= i_item;
            r_div  <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign o_div   = r_div;
endmodule
`default_nettype wire

// File: rtl/integer_alu_with_nil.sv
// ----------------------------------------------------------------------------
// integer_alu_with_nil
// signed integer alu with nil operands, when o_stall is low one beat per cycle
// ----------------------------------------------------------------------------
// usage
//   input channel i_valid / o_stall carries opcode, two operands and nil marks;
//   a beat is taken on a rising edge with i_valid high and o_stall low.
//   output channel o_valid / i_stall carries value, nil mark and status.
//   every operation, whatever its opcode, runs through the same pipeline: a
//   decode stage, a row of DATA_WIDTH divide cells (one quotient bit each) and
//   an output register.
//   throughput is one beat per cycle while o_stall is low, as the cell row then advances each cycle.
//   multiply is split into half-width partial products, summed at the output.
//   when i_stall holds the output, a skid register catches the next result and
//   only then does o_stall rise, freezing the whole pipeline until it drains.
//   reset clears all valid bits; no beat is lost or repeated across a stall.
// ----------------------------------------------------------------------------
`default_nettype none
`include "integer_alu_with_nil_macros.svh"
module integer_alu_with_nil (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [3:0]                      i_opcode,
    input  wire logic [ialu_pkg::OUT_WIDTH-1:0]  i_operand_a,
    input  wire logic [ialu_pkg::OUT_WIDTH-1:0]  i_operand_b,
    input  wire logic                            i_a_is_nil,
    input  wire logic                            i_b_is_nil,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [ialu_pkg::OUT_WIDTH-1:0]       o_result_value,
    output logic                                 o_result_nil,
    output logic [2:0]                           o_status
);
    localparam int W  = ialu_pkg::DATA_WIDTH;
    localparam int LO = ialu_pkg::LO_WIDTH;
    localparam int OW = ialu_pkg::OUT_WIDTH;

    logic                      adv;
    logic                      c_valid [0:W];
    ialu_pkg::t_item           c_item  [0:W];
    ialu_pkg::t_div            c_div   [0:W];

    logic                      r_out_valid;
    logic [OW-1:0]             r_out_value;
    logic                      r_out_nil;
    logic [2:0]                r_out_status;
    logic                      r_skid_valid;
    logic [OW-1:0]             r_skid_value;
    logic                      r_skid_nil;
    logic [2:0]                r_skid_status;

    ialu_pkg::t_item           last;
    logic [W-1:0]              mid;
    logic [W-1:0]              val;
    logic signed [W-1:0]       val_s;
    logic [OW-1:0]             fin_value;
    logic                      new_beat;

    // whole pipeline moves unless the skid register is holding a result
    assign adv     = !r_skid_valid;
    assign o_stall = r_skid_valid;

    ialu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_valid    (i_valid),
        .i_opcode   (i_opcode),
        .i_operand_a(i_operand_a),
        .i_operand_b(i_operand_b),
        .i_a_is_nil (i_a_is_nil),
        .i_b_is_nil (i_b_is_nil),
        .o_valid    (c_valid[0]),
        .o_item     (c_item[0]),
        .o_div      (c_div[0])
    );

    // row of divide cells
    for (genvar g = 0; g < W; g++) begin : g_cell
        ialu_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_adv  (adv),
            .i_valid(c_valid[g]),
            .i_item (c_item[g]),
            .i_div  (c_div[g]),
            .o_valid(c_valid[g+1]),
            .o_item (c_item[g+1]),
            .o_div  (c_div[g+1])
        );
    end

    // final value select, multiply sum and sign fixup
    always_comb begin
        last = c_item[W];
        mid  = {last.p_lh + last.p_hl, {LO{1'b0}}};
        case (last.sel)
            ialu_pkg::SEL_MUL: val = last.p_ll[W-1:0] + mid;
            ialu_pkg::SEL_DIV: val = last.q_neg ? (~c_div[W].num + 1'b1) : c_div[W].num;
            ialu_pkg::SEL_MOD: val = last.r_neg ? (~c_div[W].rem + 1'b1) : c_div[W].rem;
            default:           val = last.simple;
        endcase
        val_s     = $signed(val);
        fin_value = last.nil ? '0 : OW'(val_s);
        new_beat  = adv && c_valid[W];
    end

    // output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            r_out_valid  <= r_skid_valid || new_beat;
            r_skid_valid <= 1'b0;
        end else if (new_beat) begin
            r_skid_valid <= 1'b1;
        end
        if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out_value  <= r_skid_value;
                r_out_nil    <= r_skid_nil;
                r_out_status <= r_skid_status;
            end else begin
                r_out_value  <= fin_value;
                r_out_nil    <= last.nil;
                r_out_status <= last.status;
            end
        end else if (new_beat) begin
            r_skid_value  <= fin_value;
            r_skid_nil    <= last.nil;
            r_skid_status <= last.status;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_result_nil   = r_out_nil;
    assign o_status       = r_out_status;

    // checks
    `IALU_ASSERT_NOW(a_skid_behind_out, r_skid_valid, r_out_valid)
    `IALU_ASSERT_NEXT(a_out_held, r_out_valid && i_stall, r_out_valid)
    `IALU_ASSERT_NOW(a_nil_zero, o_valid && o_result_nil, o_result_value == '0)
    `IALU_ASSERT_NOW(a_ok_status, o_valid && !o_result_nil, o_status == ialu_pkg::ST_OK)
endmodule
`default_nettype wire

// File: tb/integer_alu_with_nil_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_alu_with_nil_test
// self-checking bench: every accepted beat is predicted in the bench and
// matched against each result, with random idling on both channels, a long
// output hold-off that fills the pipeline, and a full drain pause
// ----------------------------------------------------------------------------
module integer_alu_with_nil_test;

    localparam int W = ialu_pkg::DATA_WIDTH;
    localparam int PIPE_DEPTH = ialu_pkg::DATA_WIDTH + 2;
    localparam logic [3:0] OP_SPARE_LO = 4'd12;
    localparam logic [3:0] OP_SPARE_HI = 4'd15;
    localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] S64_MAX = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] ALL_ONES = '1;

    typedef struct {
        logic [63:0]       value;
        logic              nil;
        ialu_pkg::t_status status;
    } t_alu_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [3:0]  i_opcode;
    logic [63:0] i_operand_a;
    logic [63:0] i_operand_b;
    logic        i_a_is_nil;
    logic        i_b_is_nil;
    logic        o_valid;
    logic        i_stall;
    logic [63:0] o_result_value;
    logic        o_result_nil;
    logic [2:0]  o_status;

    t_alu_out pending_results[$];
    int       fail_count;
    int       checked_count;
    int       op_count[16];
    int       hold_len;
    bit       quiet_mode;

    integer_alu_with_nil uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_opcode(i_opcode), .i_operand_a(i_operand_a), .i_operand_b(i_operand_b),
        .i_a_is_nil(i_a_is_nil), .i_b_is_nil(i_b_is_nil), .o_valid(o_valid),
        .i_stall(i_stall), .o_result_value(o_result_value),
        .o_result_nil(o_result_nil), .o_status(o_status)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // low W bits, sign extended to 64
    function automatic logic [63:0] sext_w(input logic [63:0] v);
        return $signed(v << (64 - W)) >>> (64 - W);
    endfunction

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    // expected value, nil mark and status of one operation
    function automatic t_alu_out alu_predict(input logic [3:0] op, input logic [63:0] a_raw,
                                             input logic [63:0] b_raw, input logic a_nil,
                                             input logic b_nil);
        t_alu_out r;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] q;
        logic        unary;
        a = sext_w(a_raw);
        b = sext_w(b_raw);
        unary = (op == ialu_pkg::OP_NEG) || (op == ialu_pkg::OP_NOT);
        r.value = '0;
        r.nil = 1'b0;
        r.status = ialu_pkg::ST_OK;
        q = '0;
        if (op >= OP_SPARE_LO) return r;
        if (a_nil || (!unary && b_nil)) begin
            r.nil = 1'b1;
            r.status = ialu_pkg::ST_NIL;
            return r;
        end
        case (op) inside
            ialu_pkg::OP_ADD: q = a + b;
            ialu_pkg::OP_SUB: q = a - b;
            ialu_pkg::OP_MUL: q = a * b;
            ialu_pkg::OP_DIV, ialu_pkg::OP_MOD: begin
                if (b == 0) begin
                    r.nil = 1'b1;
                    r.status = ialu_pkg::ST_DIVZERO;
                    return r;
                end
                if (op == ialu_pkg::OP_DIV) begin
                    // most negative over minus one has no representable quotient
                    if (a == sext_w(S64_MIN >> (64 - W)) && b == ALL_ONES) begin
                        r.nil = 1'b1;
                        r.status = ialu_pkg::ST_OVERFLOW;
                        return r;
                    end
                    q = mag64(a) / mag64(b);
                    if (a[63] != b[63]) q = 64'd0 - q;
                end else begin
                    q = mag64(a) % mag64(b);
                    if (a[63]) q = 64'd0 - q;
                end
            end
            ialu_pkg::OP_AND: q = a & b;
            ialu_pkg::OP_XOR: q = a ^ b;
            ialu_pkg::OP_OR:  q = a | b;
            ialu_pkg::OP_SHL, ialu_pkg::OP_SHR: begin
                if (b[63] || b >= W) begin
                    r.nil = 1'b1;
                    r.status = ialu_pkg::ST_SHIFT;
                    return r;
                end
                if (op == ialu_pkg::OP_SHL) q = a << b[5:0];
                else q = $signed(a) >>> b[5:0];
            end
            ialu_pkg::OP_NEG: q = 64'd0 - a;
            default: q = ~a;
        endcase
        r.value = sext_w(q);
        return r;
    endfunction

    // send one beat after a random gap, record its expectation on acceptance
    task automatic send_beat(input logic [3:0] op, input logic [63:0] a, input logic [63:0] b,
                             input logic a_nil, input logic b_nil, input bit no_gap = 0);
        int gap;
        t_alu_out exp_r;
        gap = (no_gap || quiet_mode) ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        exp_r = alu_predict(op, a, b, a_nil, b_nil);
        i_valid <= 1'b1;
        i_opcode <= op;
        i_operand_a <= a;
        i_operand_b <= b;
        i_a_is_nil <= a_nil;
        i_b_is_nil <= b_nil;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(exp_r);
        op_count[op]++;
    endtask

    // lower valid and wait until every expected result is back
    task automatic drain_all();
        i_valid <= 1'b0;
        while (pending_results.size() > 0) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // operand with a bias toward edge values
    function automatic logic [63:0] rand_operand();
        case ($urandom_range(0, 9))
            0: return 64'd0;
            1: return 64'd1;
            2: return ALL_ONES;
            3: return S64_MIN;
            4: return S64_MAX;
            5: return 64'($signed($urandom_range(0, 200)) - 100);
            6: return {32'd0, $urandom()};
            default: return rand64();
        endcase
    endfunction

    // mostly legal shift counts, sometimes out of range either way
    function automatic logic [63:0] rand_shift();
        case ($urandom_range(0, 7))
            0: return 64'($signed($urandom_range(0, 70)) - 3);
            1: return rand64();
            default: return 64'($urandom_range(0, W - 1));
        endcase
    endfunction

    task automatic test_directed();
        send_beat(ialu_pkg::OP_ADD, S64_MAX, 64'd1, 0, 0);
        send_beat(ialu_pkg::OP_SUB, S64_MIN, 64'd1, 0, 0);
        send_beat(ialu_pkg::OP_MUL, S64_MAX, S64_MAX, 0, 0);
        send_beat(ialu_pkg::OP_MUL, S64_MIN, ALL_ONES, 0, 0);
        send_beat(ialu_pkg::OP_DIV, 64'd7, 64'd0, 0, 0);
        send_beat(ialu_pkg::OP_MOD, 64'd7, 64'd0, 0, 0);
        send_beat(ialu_pkg::OP_DIV, S64_MIN, ALL_ONES, 0, 0);
        send_beat(ialu_pkg::OP_MOD, S64_MIN, ALL_ONES, 0, 0);
        send_beat(ialu_pkg::OP_DIV, -64'sd7, 64'd2, 0, 0);
        send_beat(ialu_pkg::OP_MOD, -64'sd7, 64'd2, 0, 0);
        send_beat(ialu_pkg::OP_MOD, 64'd7, -64'sd2, 0, 0);
        send_beat(ialu_pkg::OP_AND, ALL_ONES, S64_MAX, 0, 0);
        send_beat(ialu_pkg::OP_XOR, ALL_ONES, S64_MIN, 0, 0);
        send_beat(ialu_pkg::OP_OR, S64_MIN, 64'd1, 0, 0);
        send_beat(ialu_pkg::OP_SHL, 64'd1, 64'(W - 1), 0, 0);
        send_beat(ialu_pkg::OP_SHL, 64'd1, 64'(W), 0, 0);
        send_beat(ialu_pkg::OP_SHR, S64_MIN, 64'(W - 1), 0, 0);
        send_beat(ialu_pkg::OP_SHR, S64_MIN, ALL_ONES, 0, 0);
        send_beat(ialu_pkg::OP_NEG, S64_MIN, 64'd0, 0, 1);
        send_beat(ialu_pkg::OP_NOT, 64'd0, 64'd0, 0, 1);
        send_beat(ialu_pkg::OP_ADD, 64'd5, 64'd0, 1, 0);
        send_beat(ialu_pkg::OP_DIV, 64'd5, 64'd0, 0, 1);
        send_beat(ialu_pkg::OP_NEG, 64'd5, 64'd0, 1, 0);
        send_beat(OP_SPARE_LO, ALL_ONES, ALL_ONES, 1, 1);
        send_beat(OP_SPARE_HI, S64_MAX, 64'd0, 0, 0);
    endtask

    task automatic send_random(input int count, input bit no_gap);
        logic [3:0] op;
        logic [63:0] b;
        for (int n = 0; n < count; n++) begin
            op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                              : 4'($urandom_range(0, 11));
            b = (op == ialu_pkg::OP_SHL || op == ialu_pkg::OP_SHR) ? rand_shift()
                                                                   : rand_operand();
            send_beat(op, rand_operand(), b, $urandom_range(0, 15) == 0,
                      $urandom_range(0, 15) == 0, no_gap);
        end
    endtask

    task automatic test_random();
        for (int chunk = 0; chunk < 10; chunk++) begin
            quiet_mode = (chunk % 4 == 3);
            send_random(180, 0);
        end
        quiet_mode = 0;
    endtask

    // output held for a long stretch while the sender keeps offering beats
    task automatic test_backpressure();
        hold_len = 300;
        send_random(150, 1);
    endtask

    task automatic test_drain_pause();
        send_random(20, 0);
        drain_all();
        send_random(30, 0);
    endtask

    // receiver: random stall ahead of each beat, plus an occasional long hold
    initial begin
        int n;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_len > 0) begin
                n = hold_len;
                hold_len = 0;
            end else begin
                n = quiet_mode ? 0 : $urandom_range(0, 19);
            end
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // result check against the oldest expectation
    always @(posedge i_clk) begin
        t_alu_out exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result value=%h nil=%b status=%0d", $time,
                         o_result_value, o_result_nil, o_status);
            end else begin
                exp_r = pending_results.pop_front();
                checked_count++;
                if (o_result_value !== exp_r.value) begin
                    fail_count++;
                    $display("%0t: value expected %h actual %h", $time, exp_r.value,
                             o_result_value);
                end
                if (o_result_nil !== exp_r.nil) begin
                    fail_count++;
                    $display("%0t: nil expected %b actual %b", $time, exp_r.nil, o_result_nil);
                end
                if (o_status !== exp_r.status) begin
                    fail_count++;
                    $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                             o_status);
                end
            end
        end
    end

    // run limit
    initial begin
        #5ms;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("Regression FAIL");
        $finish;
    end

    // test sequence
    initial begin
        fail_count = 0;
        checked_count = 0;
        hold_len = 0;
        quiet_mode = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_opcode = '0;
        i_operand_a = '0;
        i_operand_b = '0;
        i_a_is_nil = 1'b0;
        i_b_is_nil = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_backpressure();
        test_drain_pause();
        drain_all();
        repeat (PIPE_DEPTH + 20) @(posedge i_clk);
        if (pending_results.size() > 0) begin
            fail_count++;
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
        end
        $display("checked %0d results: add %0d sub %0d mul %0d div %0d mod %0d shifts %0d",
                 checked_count, op_count[ialu_pkg::OP_ADD], op_count[ialu_pkg::OP_SUB],
                 op_count[ialu_pkg::OP_MUL], op_count[ialu_pkg::OP_DIV],
                 op_count[ialu_pkg::OP_MOD],
                 op_count[ialu_pkg::OP_SHL] + op_count[ialu_pkg::OP_SHR]);
        $display("with nil operands, faults, spare opcodes, long hold-off and drain pause");
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/ialu_pkg.sv
rtl/ialu_front.sv
rtl/ialu_cell.sv
rtl/integer_alu_with_nil.sv
tb/integer_alu_with_nil_test.sv
